/* src/fpllrp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fpllrp_pkg;

  localparam int unsigned XtalW  = 26;
  localparam int unsigned DenomW = 20;
  localparam int unsigned VcoW   = 30;
  localparam int unsigned P1W    = 18;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [XtalW-1:0]  XtalReset  = 26'd25000000;
  localparam logic [DenomW-1:0] DenomReset = 20'd1048575;
  localparam logic [P1W-1:0]    P1Offset   = 18'd512;

  typedef enum logic {
    REG_CRYSTAL = 1'b0,
    REG_DENOM   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [XtalW-1:0]  crystal_hz;
    logic [DenomW-1:0] frac_denominator;
  } cfg_t;

endpackage
`default_nettype wire

/* src/fpllrp_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module fpllrp_core
  import fpllrp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [VcoW-1:0]   vco_hz_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [P1W-1:0]         p1_o,
  output logic [DenomW-1:0]      p2_o
);

  localparam int unsigned StA = VcoW;
  localparam int unsigned StB = DenomW;
  localparam int unsigned StC = 8;

  logic              en;
  logic [XtalW-1:0]  xt;
  logic [DenomW-1:0] cd;

  logic              av_q [0:StA];
  logic [XtalW-1:0]  ar_q [0:StA];
  logic [VcoW-1:0]   aw_q [0:StA];

  logic              bv_q [0:StB];
  logic [XtalW-1:0]  br_q [0:StB];
  logic [DenomW-1:0] bw_q [0:StB];
  logic [VcoW-1:0]   ba_q [0:StB];

  logic              cv_q [0:StC];
  logic [DenomW-1:0] cr_q [0:StC];
  logic [StC-1:0]    cw_q [0:StC];
  logic [VcoW-1:0]   ca_q [0:StC];

  logic              ov_q;
  logic [P1W-1:0]    p1_q;
  logic [DenomW-1:0] p2_q;

  logic [45:0]       prod;
  logic [46:0]       numer;
  logic [StC-1:0]    f;
  logic [P1W-1:0]    p1_d;

  assign en          = !ov_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = ov_q;
  assign p1_o        = p1_q;
  assign p2_o        = p2_q;
  assign xt          = (cfg_i.crystal_hz == '0) ? XtalW'(1) : cfg_i.crystal_hz;
  assign cd          = cfg_i.frac_denominator;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q[0] <= 1'b0;
    end else if (en) begin
      av_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ar_q[0] <= '0;
      aw_q[0] <= vco_hz_i;
    end
  end

  for (genvar k = 0; k < StA; k++) begin : g_a
    logic [XtalW:0]   t;
    logic [XtalW:0]   diff;
    logic             ge;
    assign t    = {ar_q[k], aw_q[k][VcoW-1]};
    assign diff = t - {1'b0, xt};
    assign ge   = t >= {1'b0, xt};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        av_q[k+1] <= 1'b0;
      end else if (en) begin
        av_q[k+1] <= av_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ar_q[k+1] <= ge ? diff[XtalW-1:0] : t[XtalW-1:0];
        aw_q[k+1] <= {aw_q[k][VcoW-2:0], ge};
      end
    end
  end

  assign prod  = {20'b0, ar_q[StA]} * {26'b0, cd};
  assign numer = {1'b0, prod} + {22'b0, xt[XtalW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q[0] <= 1'b0;
    end else if (en) begin
      bv_q[0] <= av_q[StA];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      br_q[0] <= numer[45:20];
      bw_q[0] <= numer[19:0];
      ba_q[0] <= aw_q[StA];
    end
  end

  for (genvar k = 0; k < StB; k++) begin : g_b
    logic [XtalW:0]   t;
    logic [XtalW:0]   diff;
    logic             ge;
    assign t    = {br_q[k], bw_q[k][DenomW-1]};
    assign diff = t - {1'b0, xt};
    assign ge   = t >= {1'b0, xt};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bv_q[k+1] <= 1'b0;
      end else if (en) begin
        bv_q[k+1] <= bv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        br_q[k+1] <= ge ? diff[XtalW-1:0] : t[XtalW-1:0];
        bw_q[k+1] <= {bw_q[k][DenomW-2:0], ge};
        ba_q[k+1] <= ba_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= bv_q[StB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q[0] <= {1'b0, bw_q[StB][DenomW-1:1]};
      cw_q[0] <= {bw_q[StB][0], 7'b0};
      ca_q[0] <= ba_q[StB];
    end
  end

  for (genvar k = 0; k < StC; k++) begin : g_c
    logic [DenomW:0]  t;
    logic [DenomW:0]  diff;
    logic             ge;
    assign t    = {cr_q[k], cw_q[k][StC-1]};
    assign diff = t - {1'b0, cd};
    assign ge   = t >= {1'b0, cd};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else if (en) begin
        cv_q[k+1] <= cv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        cr_q[k+1] <= ge ? diff[DenomW-1:0] : t[DenomW-1:0];
        cw_q[k+1] <= {cw_q[k][StC-2:0], ge};
        ca_q[k+1] <= ca_q[k];
      end
    end
  end

  assign f    = (cd == '0) ? '0 : cw_q[StC];
  assign p1_d = {ca_q[StC][10:0], 7'b0} + {10'b0, f} - P1Offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= cv_q[StC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      p2_q <= (cd == '0) ? '0 : cr_q[StC];
    end
  end

endmodule
`default_nettype wire

/* src/fractional_pll_register_planner_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Turns a target VCO frequency into the eight register bytes of a fractional
// feedback divider a + b/c, using the crystal frequency and denominator set
// over the APB port (crystal at address 0, denominator at address 4). The
// block is a 62-stage pipeline of one-bit restoring division steps: an input
// register, 30 for the integer part, one multiply stage, 20 for the numerator,
// one stage that sets up the fraction scale, 8 for the fraction scale and one
// output register. It takes one request per cycle; while a result waits at
// the output, the whole pipeline holds and no new request is taken.
module fractional_pll_register_planner_top
  import fpllrp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [VcoW-1:0]   vco_hz_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             reg_byte_0_o,
  output logic [7:0]             reg_byte_1_o,
  output logic [1:0]             reg_byte_2_o,
  output logic [7:0]             reg_byte_3_o,
  output logic [7:0]             reg_byte_4_o,
  output logic [7:0]             reg_byte_5_o,
  output logic [7:0]             reg_byte_6_o,
  output logic [7:0]             reg_byte_7_o
);

  cfg_t              cfg_q;
  cfg_t              cfg_d;
  reg_idx_e          idx;
  logic              wr;
  logic [P1W-1:0]    p1;
  logic [DenomW-1:0] p2;
  logic [DenomW-1:0] p3;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_CRYSTAL: cfg_d.crystal_hz       = pwdata[XtalW-1:0];
        REG_DENOM:   cfg_d.frac_denominator = pwdata[DenomW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crystal_hz       <= XtalReset;
      cfg_q.frac_denominator <= DenomReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_CRYSTAL: prdata = {6'b0, cfg_q.crystal_hz};
      REG_DENOM:   prdata = {12'b0, cfg_q.frac_denominator};
      default:     prdata = '0;
    endcase
  end

  fpllrp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .vco_hz_i    (vco_hz_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .p1_o        (p1),
    .p2_o        (p2)
  );

  assign p3           = cfg_q.frac_denominator;
  assign reg_byte_0_o = p3[15:8];
  assign reg_byte_1_o = p3[7:0];
  assign reg_byte_2_o = p1[17:16];
  assign reg_byte_3_o = p1[15:8];
  assign reg_byte_4_o = p1[7:0];
  assign reg_byte_5_o = {p3[19:16], p2[19:16]};
  assign reg_byte_6_o = p2[15:8];
  assign reg_byte_7_o = p2[7:0];

endmodule
`default_nettype wire

/* src/fpllrp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module fpllrp_checker
  import fpllrp_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic pready,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic [7:0] reg_byte_3_o,
  input wire logic [7:0] reg_byte_4_o,
  input wire logic [7:0] reg_byte_7_o
);

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reg_byte_3_o)
      && $stable(reg_byte_4_o) && $stable(reg_byte_7_o))
    else $error("stalled result changed");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

endmodule

bind fractional_pll_register_planner_top fpllrp_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pready       (pready),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .reg_byte_3_o (reg_byte_3_o),
  .reg_byte_4_o (reg_byte_4_o),
  .reg_byte_7_o (reg_byte_7_o)
);
`default_nettype wire
